### hdl/bsa_pkg.sv
// Package for the binned slab allocator: sizes, codes, bin tables, queue entry type.
// No dependencies.
`default_nettype none
package bsa_pkg;
	localparam int BIN_COUNT  = 5;
	localparam int SLAB_SLOTS = 16;
	localparam int MAX_BLOCKS = 64;
	localparam int PAGE_BYTES = 4096;
	localparam int SLOT_W = $clog2(SLAB_SLOTS);
	localparam int SPTR_W = $clog2(SLAB_SLOTS + 1);
	localparam int BLK_W  = $clog2(MAX_BLOCKS);
	localparam int BPTR_W = $clog2(MAX_BLOCKS + 1);
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam logic [SPTR_W-1:0] NIL_SLOT  = SPTR_W'(SLAB_SLOTS);
	localparam logic [BPTR_W-1:0] NIL_BLOCK = BPTR_W'(MAX_BLOCKS);

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_LARGE  = 2'd1;
	localparam logic [1:0] ST_NOSLAB = 2'd2;
	localparam logic [1:0] ST_REJECT = 2'd3;

	localparam logic [2:0] K_ALLOC   = 3'd0;
	localparam logic [2:0] K_LARGE   = 3'd1;
	localparam logic [2:0] K_FREE    = 3'd2;
	localparam logic [2:0] K_FREE_LG = 3'd3;

	function automatic logic [13:0] bin_size(input logic [2:0] b);
		return 14'(64) << b;
	endfunction

	function automatic logic [CNT_W-1:0] blocks_of(input logic [2:0] b);
		int pages, n;
		case (b)
			3'd0, 3'd1, 3'd2: pages = 1;
			3'd3: pages = 2;
			3'd4: pages = 3;
			3'd5: pages = 4;
			3'd6: pages = 8;
			default: pages = 16;
		endcase
		n = (pages * PAGE_BYTES - 64) >> (6 + int'(b));
		if (n > MAX_BLOCKS) n = MAX_BLOCKS;
		if (n < 1) n = 1;
		return CNT_W'(n);
	endfunction

	typedef struct packed {
		logic [2:0]        kind;
		logic [2:0]        bin;
		logic [3:0]        al;
		logic [32:0]       need;
		logic [SLOT_W-1:0] slot;
		logic [BLK_W-1:0]  blk;
	} cmd_t;
endpackage
`default_nettype wire

### hdl/bsa_front.sv
// Front end: accepts requests, computes size, bin and kind, pushes to the queue.
// Depends on bsa_pkg.
`default_nettype none
module bsa_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [47:0]         in_data,
	input  wire  [1:0]          in_user,
	input  wire                 q_full,
	output logic                q_push,
	output bsa_pkg::cmd_t       q_cmd
);
	import bsa_pkg::*;
	logic        mode, lg;
	logic [31:0] sz;
	logic [3:0]  al;
	logic [32:0] need;
	logic [13:0] amax;
	logic [2:0]  b;
	logic        fits;
	assign mode = in_user[0];
	assign lg   = in_user[1];
	assign sz   = (in_data[31:0] == 32'd0) ? 32'd1 : in_data[31:0];
	assign al   = (in_data[35:32] > 4'd12) ? 4'd12 : in_data[35:32];
	assign amax = (al < 4'd3) ? 14'd8 : (14'd1 << al);
	assign need = 33'd39 + 33'(amax) + 33'(sz);
	always_comb begin
		b = 3'd0;
		fits = 1'b0;
		for (int i = BIN_COUNT - 1; i >= 0; i--)
			if (need <= 33'(bin_size(3'(i)))) begin
				b = 3'(i);
				fits = 1'b1;
			end
	end
	assign in_ready = !q_full;
	assign q_push = in_valid && in_ready;
	always_comb begin
		q_cmd.bin  = b;
		q_cmd.al   = al;
		q_cmd.need = need;
		q_cmd.slot = in_data[36 +: SLOT_W];
		q_cmd.blk  = in_data[40 +: BLK_W];
		if (mode) q_cmd.kind = lg ? K_FREE_LG : K_FREE;
		else      q_cmd.kind = fits ? K_ALLOC : K_LARGE;
	end
	logic unused_q;
	assign unused_q = ^{clk, arst_n, in_data[47:46]};
endmodule
`default_nettype wire

### hdl/bsa_queue.sv
// Two-entry queue between front and back ends.
// Depends on bsa_pkg.
`default_nettype none
module bsa_queue (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           push,
	input  bsa_pkg::cmd_t din,
	output logic          full,
	output logic          nonempty,
	input  wire           pop,
	output bsa_pkg::cmd_t dout
);
	import bsa_pkg::*;
	cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	assign full = cnt_q == 2'd2;
	assign nonempty = cnt_q != 2'd0;
	assign dout = mem_q[rp_q];
	always_ff @(posedge clk) if (push) mem_q[wp_q] <= din;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

### hdl/bsa_back.sv
// Back end: sequencer over slab tables and block memories; builds one result per command.
// Depends on bsa_pkg.
`default_nettype none
module bsa_back (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           q_nonempty,
	input  bsa_pkg::cmd_t q_cmd,
	output logic          q_pop,
	output logic          out_valid,
	input  wire           out_ready,
	output logic [79:0]   out_data,
	output logic [1:0]    out_user
);
	import bsa_pkg::*;
	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001, S_DEC  = 8'b00000010, S_RD   = 8'b00000100,
		S_ALC  = 8'b00001000, S_SCAN = 8'b00010000, S_FRD  = 8'b00100000,
		S_FREE = 8'b01000000, S_OUT  = 8'b10000000
	} st_t;
	st_t st_q;
	cmd_t c_q;
	logic              in_use_q [SLAB_SLOTS];
	logic [2:0]        sbin_q   [SLAB_SLOTS];
	logic [CNT_W-1:0]  fcnt_q   [SLAB_SLOTS];
	logic [CNT_W-1:0]  bump_q   [SLAB_SLOTS];
	logic [BPTR_W-1:0] head_q   [SLAB_SLOTS];
	logic [SPTR_W-1:0] nxt_q    [SLAB_SLOTS];
	logic [SPTR_W-1:0] prv_q    [SLAB_SLOTS];
	logic [SPTR_W-1:0] bfirst_q [BIN_COUNT];
	logic [SPTR_W-1:0] bavail_q [BIN_COUNT];
	logic [SPTR_W-1:0] bres_q   [BIN_COUNT];
	localparam int MW = SLOT_W + BLK_W;
	logic              alloc_mem [SLAB_SLOTS*MAX_BLOCKS];
	logic [BPTR_W-1:0] nfree_mem [SLAB_SLOTS*MAX_BLOCKS];
	logic [BPTR_W-1:0] nfree_rd_q;
	logic              alloc_rd_q;
	logic [MW-1:0]     rd_addr, wr_addr;
	logic              nf_we;
	logic [BPTR_W-1:0] nf_wd;
	logic              al_we, al_wd;
	logic [MW-1:0]     al_wa;
	logic [SPTR_W-1:0] s_q, scan_q;
	logic [BLK_W-1:0]  blk_q;
	logic [1:0]        ost_q;
	logic [74:0]       od_q;
	logic [2:0]        bb;
	logic [SLOT_W-1:0] s;
	logic [SLOT_W-1:0] freeslot;
	logic              freefound;
	logic [13:0]       boff;
	logic [13:0]       bsz;
	logic [13:0]       amask;
	logic [13:0]       uoff;
	logic [CNT_W-1:0]  nb;
	logic [CNT_W-1:0]  fnb;
	logic [BLK_W-1:0]  alc_blk;
	logic              free_ok;
	assign bb = c_q.bin;
	assign s = s_q[SLOT_W-1:0];
	assign bsz = bin_size(bb);
	assign nb = blocks_of(bb);
	assign fnb = blocks_of(sbin_q[s]);
	assign boff = 14'd64 + (14'(blk_q) << (6 + int'(bb)));
	assign amask = (14'd1 << c_q.al) - 14'd1;
	always_comb begin
		freeslot = '0; freefound = 1'b0;
		for (int i = SLAB_SLOTS - 1; i >= 0; i--)
			if (!in_use_q[i]) begin freeslot = SLOT_W'(i); freefound = 1'b1; end
	end
	assign uoff = ((boff + 14'd40 + amask) & ~amask) - boff;
	// recycled block first, else the next fresh block from the bump count
	assign alc_blk = (head_q[s] != NIL_BLOCK) ? head_q[s][BLK_W-1:0]
		: BLK_W'(nb - bump_q[s]);
	// a block at or past the bump point was never handed out since the slab
	// was set up, so its stored flag is stale and it counts as free
	assign free_ok = in_use_q[s] && sbin_q[s] < 3'(BIN_COUNT)
		&& CNT_W'(blk_q) < fnb && CNT_W'(blk_q) < fnb - bump_q[s] && alloc_rd_q;
	assign rd_addr = (st_q == S_DEC) ? {c_q.slot, c_q.blk}
		: {s, head_q[s][BLK_W-1:0]};
	assign q_pop = (st_q == S_IDLE) && q_nonempty;
	assign out_valid = st_q == S_OUT;
	assign out_data = {7'd0, od_q[74:2]};
	assign out_user = od_q[1:0];
	assign wr_addr = {s, blk_q};
	assign nf_we = (st_q == S_FRD) && free_ok;
	assign nf_wd = head_q[s];
	assign al_we = (st_q == S_ALC) || ((st_q == S_FRD) && free_ok);
	assign al_wa = (st_q == S_ALC) ? {s, alc_blk} : {s, blk_q};
	assign al_wd = st_q == S_ALC;
	always_ff @(posedge clk) begin
		nfree_rd_q <= nfree_mem[rd_addr];
		if (nf_we) nfree_mem[wr_addr] <= nf_wd;
	end
	always_ff @(posedge clk) begin
		alloc_rd_q <= alloc_mem[{c_q.slot, c_q.blk}];
		if (al_we) alloc_mem[al_wa] <= al_wd;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			for (int i = 0; i < SLAB_SLOTS; i++) begin
				in_use_q[i] <= 1'b0; sbin_q[i] <= '0; fcnt_q[i] <= '0; bump_q[i] <= '0;
				head_q[i] <= NIL_BLOCK; nxt_q[i] <= NIL_SLOT; prv_q[i] <= NIL_SLOT;
			end
			for (int i = 0; i < BIN_COUNT; i++) begin
				bfirst_q[i] <= NIL_SLOT; bavail_q[i] <= NIL_SLOT; bres_q[i] <= NIL_SLOT;
			end
			c_q <= '0; s_q <= '0; scan_q <= '0; blk_q <= '0;
			ost_q <= '0; od_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: if (q_nonempty) begin c_q <= q_cmd; st_q <= S_DEC; end
				S_DEC: begin
					blk_q <= c_q.blk;
					case (c_q.kind)
						K_LARGE: begin
							od_q <= {c_q.need, 13'((14'd40 + amask) & ~amask),
								14'd0, 6'd0, 4'd0, 3'd0, ST_LARGE};
							st_q <= S_OUT;
						end
						K_FREE_LG: begin od_q <= {73'd0, ST_LARGE}; st_q <= S_OUT; end
						K_FREE: begin s_q <= SPTR_W'(c_q.slot); st_q <= S_FRD; end
						default: begin
							if (bavail_q[bb] != NIL_SLOT) begin
								s_q <= bavail_q[bb]; st_q <= S_RD;
							end else if (bres_q[bb] != NIL_SLOT || freefound) begin
								logic [SPTR_W-1:0] ns;
								ns = (bres_q[bb] != NIL_SLOT) ? bres_q[bb] : SPTR_W'(freeslot);
								if (bres_q[bb] != NIL_SLOT) bres_q[bb] <= NIL_SLOT;
								else begin
									in_use_q[freeslot] <= 1'b1; sbin_q[freeslot] <= bb;
									fcnt_q[freeslot] <= nb; bump_q[freeslot] <= nb;
									head_q[freeslot] <= NIL_BLOCK;
								end
								prv_q[ns[SLOT_W-1:0]] <= NIL_SLOT;
								nxt_q[ns[SLOT_W-1:0]] <= bfirst_q[bb];
								if (bfirst_q[bb] != NIL_SLOT)
									prv_q[bfirst_q[bb][SLOT_W-1:0]] <= ns;
								bfirst_q[bb] <= ns; bavail_q[bb] <= ns;
								s_q <= ns; st_q <= S_RD;
							end else begin
								od_q <= {70'd0, bb, ST_NOSLAB}; st_q <= S_OUT;
							end
						end
					endcase
				end
				S_RD: st_q <= S_ALC;
				S_ALC: begin
					if (head_q[s] != NIL_BLOCK) head_q[s] <= nfree_rd_q;
					else bump_q[s] <= bump_q[s] - 1'b1;
					blk_q <= alc_blk;
					fcnt_q[s] <= fcnt_q[s] - 1'b1;
					ost_q <= ST_OK;
					scan_q <= nxt_q[s];
					st_q <= (fcnt_q[s] == CNT_W'(1)) ? S_SCAN : S_FREE;
				end
				S_SCAN: begin
					if (scan_q == NIL_SLOT || fcnt_q[scan_q[SLOT_W-1:0]] != '0) begin
						bavail_q[bb] <= scan_q; st_q <= S_FREE;
					end else scan_q <= nxt_q[scan_q[SLOT_W-1:0]];
				end
				S_FRD: begin
					logic [2:0] fb;
					logic [CNT_W-1:0] fn, nc;
					logic [SPTR_W-1:0] pv, nx, fa;
					fb = sbin_q[s]; fn = fnb; nc = fcnt_q[s] + 1'b1;
					pv = prv_q[s]; nx = nxt_q[s]; fa = bavail_q[fb];
					if (!free_ok) begin
						od_q <= {73'd0, ST_REJECT}; st_q <= S_OUT;
					end else begin
						c_q.bin <= fb;
						ost_q <= ST_OK;
						if (nc >= fn) begin
							if (pv != NIL_SLOT) begin
								nxt_q[pv[SLOT_W-1:0]] <= nx;
								if (nx != NIL_SLOT) prv_q[nx[SLOT_W-1:0]] <= pv;
							end else begin
								bfirst_q[fb] <= nx;
								if (nx != NIL_SLOT) prv_q[nx[SLOT_W-1:0]] <= NIL_SLOT;
							end
							prv_q[s] <= NIL_SLOT; nxt_q[s] <= NIL_SLOT;
							if (bres_q[fb] == NIL_SLOT) begin
								bres_q[fb] <= s_q;
								head_q[s] <= BPTR_W'(blk_q);
								fcnt_q[s] <= nc;
							end else begin
								in_use_q[s] <= 1'b0; sbin_q[s] <= '0; fcnt_q[s] <= '0;
								bump_q[s] <= '0; head_q[s] <= NIL_BLOCK;
							end
							if (fa == s_q) begin
								scan_q <= (pv != NIL_SLOT) ? bfirst_q[fb] : nx;
								st_q <= S_SCAN;
							end else st_q <= S_FREE;
						end else begin
							head_q[s] <= BPTR_W'(blk_q);
							fcnt_q[s] <= nc;
							st_q <= S_FREE;
							if (fa == NIL_SLOT || nc > fcnt_q[fa[SLOT_W-1:0]])
								bavail_q[fb] <= s_q;
						end
					end
				end
				S_FREE: begin
					// build result; user offset is zero on frees
					od_q <= {19'd0, bsz,
						(c_q.kind == K_ALLOC) ? uoff[12:0] : 13'd0,
						boff, blk_q, s, bb, ost_q};
					st_q <= S_OUT;
				end
				S_OUT: if (out_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### hdl/binned_slab_allocator.sv
// Top level of the binned slab allocator: front end, queue, back end.
// Depends on bsa_pkg, bsa_front, bsa_queue, bsa_back.
// A request is classified in the front end in the cycle it transfers and is
// queued (two entries) for the back-end sequencer, which pops one command at a
// time from idle. A large allocation, a large free or an out-of-slab answer
// goes from decode straight to the output; a free reads its registered block
// flag, then either rejects or updates the slab and builds the result; a binned
// allocation reads the slab's free list, takes a block and builds the result.
// When an allocation fills its slab, or a free retires or parks the
// first-available slab, a scan walks the bin's slab list past slabs with no free
// block. Each result is held until m_tready is high. The front keeps taking
// requests while the queue has room, also while a result waits. Block memories
// need no clearing after reset: a block index at or past a slab's bump point
// counts as free whatever its stored allocation flag holds.
`default_nettype none
module binned_slab_allocator (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [47:0] s_tdata, // request_size, align_log2, free_slot,
	                              // free_block, zero pad
	input  wire  [1:0]  s_tuser, // mode, free_is_large
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [79:0] m_tdata, // bin, slot, block, block_offset,
	                              // user_offset, capacity, zero pad
	output logic [1:0]  m_tuser  // status
);
	import bsa_pkg::*;
	cmd_t f_cmd, q_out;
	logic f_push, q_full, q_ne, q_pop;
	bsa_front u_front (.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready),
		.in_data(s_tdata), .in_user(s_tuser), .q_full, .q_push(f_push), .q_cmd(f_cmd));
	bsa_queue u_queue (.clk, .arst_n, .push(f_push), .din(f_cmd), .full(q_full),
		.nonempty(q_ne), .pop(q_pop), .dout(q_out));
	bsa_back u_back (.clk, .arst_n, .q_nonempty(q_ne), .q_cmd(q_out), .q_pop,
		.out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata),
		.out_user(m_tuser));
endmodule
`default_nettype wire

### hdl/bsa_checker.sv
// Port-level checker for the allocator, bound to the top level.
// Depends on bsa_pkg and binned_slab_allocator ports.
`default_nettype none
module bsa_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [79:0] m_tdata,
	input wire [1:0]  m_tuser
);
	import bsa_pkg::*;
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("out hold");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[79:73] == 7'd0) else $error("pad");
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_REJECT |-> m_tdata == 80'd0) else $error("reject");
	a_bin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_OK |-> m_tdata[2:0] < 3'(BIN_COUNT)) else $error("bin");
endmodule
bind binned_slab_allocator bsa_checker u_chk (.clk, .arst_n,
	.m_tvalid, .m_tready, .m_tdata, .m_tuser);
`default_nettype wire

### dv/binned_slab_allocator_tb.sv
// Self-checking testbench for binned_slab_allocator: directed table, then random traffic.
// Depends on bsa_pkg and the binned_slab_allocator RTL; carries its own allocator predictor.
`timescale 1ns/1ps
`default_nettype none
module binned_slab_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bsa_pkg::*;

	localparam int NILS       = SLAB_SLOTS;
	localparam int NILB       = MAX_BLOCKS;
	localparam int IDLE_LIMIT = 5000;
	localparam int PHASE_LEN  = 300;

	// result layout, lowest bits first: status, bin, slot, block, block_offset, user_offset, capacity
	typedef struct packed {
		logic [32:0] cap;
		logic [12:0] uoff;
		logic [13:0] boff;
		logic [5:0]  blk;
		logic [3:0]  slot;
		logic [2:0]  bin;
		logic [1:0]  status;
	} alloc_res_t;

	typedef struct {
		bit        mode;
		bit [31:0] size;
		bit [3:0]  al;
		bit        lg;
		bit [3:0]  fslot;
		bit [5:0]  fblk;
		bit        typed;
		bit [1:0]  st;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic [1:0]  m_tuser;

	binned_slab_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// predictor state
	bit      used   [NILS];
	int      sbin   [NILS];
	int      fcnt   [NILS];
	int      bump   [NILS];
	int      fhead  [NILS];
	int      snext  [NILS];
	int      sprev  [NILS];
	bit      alloc_flag [NILS*NILB];
	int      nextfree   [NILS*NILB];
	int      first_slab [BIN_COUNT];
	int      first_avail[BIN_COUNT];
	int      reserve    [BIN_COUNT];

	alloc_res_t expected_q[$];
	int         live_slot[$];
	int         live_blk[$];
	int         mismatches;
	int         stall_pct;
	int         gap_pct;
	int         idle_cnt;

	function automatic int blk_size(int b);
		return 64 << b;
	endfunction

	function automatic int slab_blocks(int b);
		int pages[5] = '{1, 1, 1, 2, 3};
		int n;
		n = (pages[b] * PAGE_BYTES - 64) / blk_size(b);
		if (n > MAX_BLOCKS) n = MAX_BLOCKS;
		if (n < 1) n = 1;
		return n;
	endfunction

	function automatic longint unsigned payload_off(longint unsigned start, longint unsigned a);
		longint unsigned p;
		p = start + 40;
		return ((p + a - 1) & ~(a - 1)) - start;
	endfunction

	function automatic int next_with_room(int s);
		while (s < NILS && fcnt[s] == 0) s = snext[s];
		return s;
	endfunction

	function automatic void clear_model();
		for (int i = 0; i < NILS; i++) begin
			used[i] = 0; sbin[i] = 0; fcnt[i] = 0; bump[i] = 0;
			fhead[i] = NILB; snext[i] = NILS; sprev[i] = NILS;
		end
		for (int i = 0; i < NILS*NILB; i++) begin
			alloc_flag[i] = 0; nextfree[i] = 0;
		end
		for (int i = 0; i < BIN_COUNT; i++) begin
			first_slab[i] = NILS; first_avail[i] = NILS; reserve[i] = NILS;
		end
	endfunction

	function automatic alloc_res_t predict_alloc(bit [31:0] req, bit [3:0] al_in);
		alloc_res_t r;
		longint unsigned size, a, need, boff;
		int al, b, s, blk;
		r = '0;
		size = (req == 0) ? 1 : req;
		al = (al_in > 12) ? 12 : al_in;
		a = longint'(1) << al;
		need = 32 + ((a > 8) ? a : 8) - 1 + 8 + size;
		for (b = 0; b < BIN_COUNT; b++)
			if (need <= blk_size(b)) break;
		if (b >= BIN_COUNT) begin
			r.status = ST_LARGE;
			r.uoff = payload_off(0, a);
			r.cap = need;
			return r;
		end
		r.bin = b;
		if (first_avail[b] >= NILS) begin
			if (reserve[b] < NILS) begin
				s = reserve[b];
				reserve[b] = NILS;
			end else begin
				for (s = 0; s < NILS; s++)
					if (!used[s]) break;
				if (s >= NILS) begin
					r.status = ST_NOSLAB;
					return r;
				end
				used[s] = 1; sbin[s] = b;
				fcnt[s] = slab_blocks(b); bump[s] = slab_blocks(b);
				fhead[s] = NILB;
			end
			sprev[s] = NILS;
			snext[s] = first_slab[b];
			if (first_slab[b] < NILS) sprev[first_slab[b]] = s;
			first_slab[b] = s;
			first_avail[b] = s;
		end
		s = first_avail[b];
		if (fhead[s] < NILB) begin
			// recycled blocks go out first, most recently freed on top
			blk = fhead[s];
			fhead[s] = nextfree[s*NILB + blk];
		end else if (bump[s] > 0) begin
			blk = slab_blocks(b) - bump[s];
			bump[s]--;
		end else begin
			r.status = ST_NOSLAB;
			return r;
		end
		if (fcnt[s] > 0) fcnt[s]--;
		alloc_flag[s*NILB + blk] = 1;
		nextfree[s*NILB + blk] = NILB;
		if (fcnt[s] == 0) first_avail[b] = next_with_room(snext[s]);
		boff = 64 + longint'(blk) * blk_size(b);
		r.status = ST_OK; r.slot = s; r.blk = blk; r.boff = boff;
		r.uoff = payload_off(boff, a);
		r.cap = blk_size(b);
		return r;
	endfunction

	function automatic alloc_res_t predict_free(bit lg, int s, int blk);
		alloc_res_t r;
		int b, n, pv, nx, fa;
		r = '0;
		if (lg) begin
			r.status = ST_LARGE;
			return r;
		end
		r.status = ST_REJECT;
		if (s >= NILS || !used[s]) return r;
		b = sbin[s];
		n = slab_blocks(b);
		if (blk >= n || !alloc_flag[s*NILB + blk]) return r;
		alloc_flag[s*NILB + blk] = 0;
		nextfree[s*NILB + blk] = fhead[s];
		fhead[s] = blk;
		fcnt[s]++;
		if (fcnt[s] >= n) begin
			// slab wholly free: unlink, then park as reserve or retire
			pv = sprev[s]; nx = snext[s];
			if (pv < NILS) begin
				snext[pv] = nx;
				if (nx < NILS) sprev[nx] = pv;
			end else begin
				first_slab[b] = nx;
				if (nx < NILS) sprev[nx] = NILS;
			end
			sprev[s] = NILS; snext[s] = NILS;
			if (first_avail[b] == s) first_avail[b] = next_with_room(first_slab[b]);
			if (reserve[b] >= NILS) reserve[b] = s;
			else begin
				used[s] = 0; sbin[s] = 0; fcnt[s] = 0; bump[s] = 0; fhead[s] = NILB;
			end
		end else begin
			fa = first_avail[b];
			if (fa >= NILS || fcnt[s] > fcnt[fa]) first_avail[b] = s;
		end
		r.status = ST_OK; r.bin = b; r.slot = s; r.blk = blk;
		r.boff = 64 + blk * blk_size(b);
		r.cap = blk_size(b);
		return r;
	endfunction

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// result checker: oldest expectation first
	always @(posedge clk) begin
		alloc_res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[72:0], m_tuser};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				want = expected_q.pop_front();
				if (got.status !== want.status || got.bin !== want.bin ||
				    got.slot !== want.slot || got.blk !== want.blk ||
				    got.boff !== want.boff || got.uoff !== want.uoff ||
				    got.cap !== want.cap) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp st=%0d bin=%0d slot=%0d blk=%0d boff=%0d uoff=%0d cap=%0d, got st=%0d bin=%0d slot=%0d blk=%0d boff=%0d uoff=%0d cap=%0d",
						         want.status, want.bin, want.slot, want.blk, want.boff,
						         want.uoff, want.cap, got.status, got.bin, got.slot,
						         got.blk, got.boff, got.uoff, got.cap);
				end
			end
		end
	end

	// stall watchdog: cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
		else idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= IDLE_LIMIT) begin
			$display("FAIL binned_slab_allocator");
			$finish;
		end
	end

	// drive one request and predict its result at the transfer edge
	task automatic send_req(bit mode, bit [31:0] size, bit [3:0] al, bit lg,
	                        bit [3:0] fslot, bit [5:0] fblk, bit typed, bit [1:0] st);
		alloc_res_t r;
		while ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, fblk, fslot, al, size};
		s_tuser  <= {lg, mode};
		do @(posedge clk); while (!s_tready);
		if (mode) r = predict_free(lg, fslot, fblk);
		else r = predict_alloc(size, al);
		if (typed && r.status != st) begin
			mismatches++;
			if (mismatches <= 10) $display("table row expects status %0d, predicted %0d", st, r.status);
		end
		expected_q.push_back(r);
		// track live binned blocks so frees can target them
		if (r.status == ST_OK && !mode) begin
			live_slot.push_back(r.slot);
			live_blk.push_back(r.blk);
		end else if (r.status == ST_OK && mode) begin
			foreach (live_slot[i])
				if (live_slot[i] == fslot && live_blk[i] == fblk) begin
					live_slot.delete(i);
					live_blk.delete(i);
					break;
				end
		end
	endtask

	dir_row_t dir_tab[19];

	initial begin
		int phase, n, idx, pick;
		bit mode, lg;
		bit [31:0] size;
		bit [3:0] al, fslot;
		bit [5:0] fblk;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		mismatches = 0;
		stall_pct = 0;
		gap_pct = 0;
		clear_model();
		//            mode size          al  lg slot blk typed st
		dir_tab = '{
			'{1, 32'd0,         4'd0,  0, 4'd0,  6'd0,  1, ST_REJECT}, // free before any alloc
			'{1, 32'd0,         4'd0,  1, 4'd0,  6'd0,  1, ST_LARGE},  // large free
			'{0, 32'd0,         4'd0,  0, 4'd0,  6'd0,  0, ST_OK},     // zero size
			'{0, 32'd17,        4'd3,  0, 4'd0,  6'd0,  0, ST_OK},     // top of smallest bin
			'{0, 32'd18,        4'd0,  0, 4'd0,  6'd0,  0, ST_OK},
			'{0, 32'd977,       4'd0,  0, 4'd0,  6'd0,  0, ST_OK},     // top of largest bin
			'{0, 32'd978,       4'd0,  0, 4'd0,  6'd0,  1, ST_LARGE},  // just past all bins
			'{0, 32'hFFFFFFFF,  4'd15, 0, 4'd0,  6'd0,  1, ST_LARGE},  // max size, clamped align
			'{0, 32'd1,         4'd12, 0, 4'd0,  6'd0,  1, ST_LARGE},  // page alignment
			'{0, 32'd1,         4'd9,  0, 4'd0,  6'd0,  0, ST_OK},
			'{0, 32'd200,       4'd4,  0, 4'd0,  6'd0,  0, ST_OK},
			'{0, 32'd471,       4'd3,  0, 4'd0,  6'd0,  0, ST_OK},
			'{1, 32'd0,         4'd0,  0, 4'd0,  6'd0,  0, ST_OK},
			'{1, 32'd0,         4'd0,  0, 4'd0,  6'd0,  1, ST_REJECT}, // double free
			'{1, 32'd0,         4'd0,  0, 4'd0,  6'd63, 1, ST_REJECT}, // index past slab
			'{1, 32'd0,         4'd0,  0, 4'd15, 6'd0,  1, ST_REJECT}, // slot not in use
			'{1, 32'd0,         4'd0,  1, 4'd15, 6'd62, 1, ST_LARGE},
			'{0, 32'd0,         4'd13, 0, 4'd0,  6'd0,  1, ST_LARGE},
			'{1, 32'd0,         4'd0,  0, 4'd1,  6'd0,  0, ST_OK}
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_req(dir_tab[i].mode, dir_tab[i].size, dir_tab[i].al, dir_tab[i].lg,
			         dir_tab[i].fslot, dir_tab[i].fblk, dir_tab[i].typed, dir_tab[i].st);

		// idling phases: none, sender gaps, receiver stalls, both light
		for (phase = 0; phase < 4; phase++) begin
			gap_pct   = (phase == 1) ? 79 : (phase == 3) ? 12 : 0;
			stall_pct = (phase == 2) ? 79 : (phase == 3) ? 12 : 0;
			for (n = 0; n < PHASE_LEN; n++) begin
				// fill for the first half of a phase, drain for the second
				mode = ($urandom_range(0, 99) >= ((n < PHASE_LEN/2) ? 88 : 35));
				size = 0; al = 0; lg = 0; fslot = 0; fblk = 0;
				pick = $urandom_range(0, 99);
				if (!mode) begin
					if (pick < 70) begin
						size = $urandom_range(0, 983);
						al = $urandom_range(0, 5);
					end else if (pick < 88) begin
						size = $urandom_range(0, 2000);
						al = $urandom_range(0, 15);
					end else begin
						size = $urandom;
						al = $urandom_range(0, 15);
					end
				end else if (pick < 85 && live_slot.size() > 0) begin
					idx = $urandom_range(0, live_slot.size() - 1);
					fslot = live_slot[idx];
					fblk = live_blk[idx];
				end else begin
					lg = (pick >= 95);
					fslot = $urandom_range(0, 15);
					fblk = $urandom_range(0, 63);
				end
				send_req(mode, size, al, lg, fslot, fblk, 0, ST_OK);
			end
		end
		s_tvalid <= 1'b0;

		wait (expected_q.size() == 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0) $display("PASS binned_slab_allocator");
		else $display("FAIL binned_slab_allocator");
		$finish;
	end

	// a result left waiting would otherwise hang in the wait above; the watchdog ends it
endmodule
`default_nettype wire

### filelist.f
hdl/bsa_pkg.sv
hdl/bsa_front.sv
hdl/bsa_queue.sv
hdl/bsa_back.sv
hdl/binned_slab_allocator.sv
hdl/bsa_checker.sv
dv/binned_slab_allocator_tb.sv
